// ===== src/pointer_handle_translation_table_assert.svh =====
// Assertion macros used by the translation table datapath.
`ifndef POINTER_HANDLE_TRANSLATION_TABLE_ASSERT_SVH
`define POINTER_HANDLE_TRANSLATION_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PHTT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("phtt: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PHTT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("phtt: assertion failed");

`endif

// ===== src/phtt_pkg.sv =====
package phtt_pkg;

  // Table geometry and field widths.
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned FuncW           = 2;
  localparam int unsigned ValueW          = 64;
  localparam int unsigned StatusW         = 3;
  localparam int unsigned IndexW          = 23;
  localparam int unsigned HandleW         = 32;
  localparam int unsigned InTdataW        = 72;
  localparam int unsigned OutTdataW       = 72;

  // Handle pattern: marker nibbles at both ends, index at bit 4.
  localparam logic [HandleW-1:0] HandleMark = 32'hF000000F;
  localparam logic [IndexW-1:0]  IndexMask  = 23'h7FFFFF;
  localparam logic [IndexW-1:0]  IndexReset = 23'd1;

  // Configuration port.
  localparam int unsigned PaddrW      = 3;
  localparam int unsigned PdataW      = 32;
  localparam logic        RegIdxEnable = 1'b0;

  typedef enum logic [FuncW-1:0] {
    FUNC_V2H     = 2'd0,
    FUNC_H2V     = 2'd1,
    FUNC_V2H_DEL = 2'd2
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_PASS  = 3'd0,
    ST_ONES  = 3'd1,
    ST_FOUND = 3'd2,
    ST_ALLOC = 3'd3,
    ST_MISS  = 3'd4,
    ST_FULL  = 3'd5,
    ST_OFF   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_RESOLVE,
    FSM_DONE
  } fsm_state_e;

  // One table slot as stored in memory.
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] value;
    logic [IndexW-1:0] sidx;
  } slot_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic clear_step;
    logic scan_step;
    logic resolve;
    logic load_out;
  } phtt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic immediate;
    logic out_free;
  } phtt_sts_t;

  // Handle that belongs to a slot index.
  function automatic logic [HandleW-1:0] handle_of(logic [IndexW-1:0] idx);
    handle_of = HandleMark | {5'b0, idx & IndexMask, 4'b0};
  endfunction

endpackage

// ===== src/phtt_ram.sv =====
module phtt_ram import phtt_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/phtt_ctrl.sv =====
module phtt_ctrl import phtt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  phtt_sts_t sts_i,
  output phtt_cmd_t cmd_o
);

  fsm_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.immediate ? FSM_DONE : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = FSM_RESOLVE;
        end
      end
      FSM_RESOLVE: begin
        state_d = FSM_DONE;
      end
      FSM_DONE: begin
        if (sts_i.out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_CLEAR;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      FSM_CLEAR: begin
        cmd_o.clear_step = 1'b1;
      end
      FSM_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      FSM_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      FSM_RESOLVE: begin
        cmd_o.resolve = 1'b1;
      end
      FSM_DONE: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/phtt_dp.sv =====
`include "pointer_handle_translation_table_assert.svh"

module phtt_dp import phtt_pkg::*; #(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  phtt_cmd_t            cmd_i,
  output phtt_sts_t            sts_o,
  input  logic                 enable_i,
  input  logic [InTdataW-1:0]  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OutTdataW-1:0] out_data_o
);

  localparam int unsigned AddrW = $clog2(TableEntries);
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned SlotW = $bits(slot_t);

  // Request fields.
  func_e              in_func;
  logic [ValueW-1:0]  in_val;
  logic [HandleW-1:0] in_h;
  assign in_func = func_e'(in_data_i[FuncW-1:0]);
  assign in_val  = in_data_i[FuncW+ValueW-1:FuncW];
  assign in_h    = in_val[HandleW-1:0];

  // Control registers.
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              cmp_v_q, cmp_v_d;
  logic              hit_q, hit_d;
  logic              free_q, free_d;
  logic [IndexW-1:0] next_idx_q, next_idx_d;
  logic              m_valid_q, m_valid_d;

  // Payload registers.
  func_e              func_q;
  logic [ValueW-1:0]  val_q;
  logic [AddrW-1:0]   cmp_idx_q;
  logic [AddrW-1:0]   hit_idx_q, free_idx_q;
  logic [ValueW-1:0]  hit_val_q;
  logic [IndexW-1:0]  hit_sidx_q;
  logic [ValueW-1:0]  res_q, res_d;
  status_e            st_q, st_d;
  logic [ValueW-1:0]  out_res_q;
  status_e            out_st_q;

  // Table memory.
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  slot_t            ram_wslot, ram_rslot;
  logic [SlotW-1:0] ram_rdata;

  logic issue;
  assign issue = cmd_i.scan_step && (cnt_q != CntW'(TableEntries));

  phtt_ram #(
    .Width (SlotW),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wslot),
    .re_i    (ram_re),
    .raddr_i (cnt_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign ram_re    = issue;
  assign ram_rslot = slot_t'(ram_rdata);

  // Bypass cases that never touch the table.
  logic         imm;
  logic [ValueW-1:0] imm_res;
  status_e      imm_st;
  logic         above_split;
  always_comb begin
    above_split = (in_val[ValueW-1:33] != '0) || (in_val[32] && (in_h != '0));
    imm     = 1'b0;
    imm_res = '0;
    imm_st  = ST_MISS;
    case (in_func)
      FUNC_H2V: begin
        if ((in_h & HandleMark) != HandleMark) begin
          imm = 1'b1; imm_res = {32'b0, in_h}; imm_st = ST_PASS;
        end else if (in_h == '1) begin
          imm = 1'b1; imm_res = '1; imm_st = ST_ONES;
        end else if (!enable_i) begin
          imm = 1'b1; imm_res = '0; imm_st = ST_OFF;
        end
      end
      FUNC_V2H, FUNC_V2H_DEL: begin
        if (above_split && ((in_h & HandleMark) != HandleMark)) begin
          imm = 1'b1; imm_res = {32'b0, in_h}; imm_st = ST_PASS;
        end else if (in_val == '1) begin
          imm = 1'b1; imm_res = {32'b0, 32'hFFFFFFFF}; imm_st = ST_ONES;
        end else if (!enable_i) begin
          imm = 1'b1; imm_res = '0; imm_st = ST_OFF;
        end
      end
      default: begin
        imm = 1'b1; imm_res = '0; imm_st = ST_MISS;
      end
    endcase
  end

  // Slot match for the pending request.
  logic match;
  always_comb begin
    if (func_q == FUNC_H2V) begin
      match = ram_rslot.valid && !val_q[27] && (ram_rslot.sidx == val_q[26:4]);
    end else begin
      match = ram_rslot.valid && (ram_rslot.value == val_q);
    end
  end

  // Outcome of a request, the slot write it causes, and the clearing-pass slot writes.
  always_comb begin
    res_d      = res_q;
    st_d       = st_q;
    next_idx_d = next_idx_q;
    ram_we     = 1'b0;
    ram_waddr  = cnt_q[AddrW-1:0];
    ram_wslot  = '0;
    if (cmd_i.clear_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.accept) begin
      res_d = imm_res;
      st_d  = imm_st;
    end else if (cmd_i.resolve) begin
      case (func_q)
        FUNC_H2V: begin
          if (hit_q) begin
            res_d = hit_val_q; st_d = ST_FOUND;
          end else begin
            res_d = {32'b0, val_q[HandleW-1:0]}; st_d = ST_MISS;
          end
        end
        FUNC_V2H: begin
          if (hit_q) begin
            res_d = {32'b0, handle_of(hit_sidx_q)}; st_d = ST_FOUND;
          end else if (free_q) begin
            ram_we     = 1'b1;
            ram_waddr  = free_idx_q;
            ram_wslot  = '{valid: 1'b1, value: val_q, sidx: next_idx_q};
            next_idx_d = next_idx_q + IndexW'(1);
            res_d      = {32'b0, handle_of(next_idx_q)};
            st_d       = ST_ALLOC;
          end else begin
            res_d = '0; st_d = ST_FULL;
          end
        end
        FUNC_V2H_DEL: begin
          if (hit_q) begin
            ram_we    = 1'b1;
            ram_waddr = hit_idx_q;
            ram_wslot = '{valid: 1'b0, value: hit_val_q, sidx: hit_sidx_q};
            res_d     = {32'b0, handle_of(hit_sidx_q)};
            st_d      = ST_FOUND;
          end else begin
            res_d = '0; st_d = ST_MISS;
          end
        end
        default: begin
          res_d = '0; st_d = ST_MISS;
        end
      endcase
    end
  end

  // Scan and clearing sweep counter, first-match and first-free tracking.
  always_comb begin
    cnt_d   = cnt_q;
    cmp_v_d = 1'b0;
    hit_d   = hit_q;
    free_d  = free_q;
    if (cmd_i.accept) begin
      cnt_d  = '0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (cmd_i.clear_step || issue) begin
      cnt_d   = cnt_q + CntW'(1);
      cmp_v_d = issue;
    end
    if (cmp_v_q) begin
      if (match) begin
        hit_d = 1'b1;
      end
      if (!ram_rslot.valid) begin
        free_d = 1'b1;
      end
    end
  end

  // Output register.
  assign m_valid_d = cmd_i.load_out || (m_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      cmp_v_q    <= 1'b0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      next_idx_q <= IndexReset;
      m_valid_q  <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      cmp_v_q    <= cmp_v_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      next_idx_q <= next_idx_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= in_func;
      val_q  <= in_val;
    end
    if (issue) begin
      cmp_idx_q <= cnt_q[AddrW-1:0];
    end
    if (cmp_v_q && match && !hit_q) begin
      hit_idx_q  <= cmp_idx_q;
      hit_val_q  <= ram_rslot.value;
      hit_sidx_q <= ram_rslot.sidx;
    end
    if (cmp_v_q && !ram_rslot.valid && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
    res_q <= res_d;
    st_q  <= st_d;
    if (cmd_i.load_out) begin
      out_res_q <= res_q;
      out_st_q  <= st_q;
    end
  end

  // Status to the controller and output port.
  assign sts_o.clear_last = (cnt_q == CntW'(TableEntries - 1));
  assign sts_o.scan_done  = (cnt_q == CntW'(TableEntries)) && !cmp_v_q;
  assign sts_o.immediate  = imm;
  assign sts_o.out_free   = !m_valid_q || out_ready_i;

  assign out_valid_o = m_valid_q;
  assign out_data_o  = {5'b0, out_st_q, out_res_q};

  // A result is loaded only when the output register can take it.
  `PHTT_ASSERT_IMPL(a_load_into_free, clk_i, rst_ni, cmd_i.load_out, (!m_valid_q || out_ready_i))
  // A table write on resolve needs a found slot or a free one.
  `PHTT_ASSERT_IMPL(a_write_has_slot, clk_i, rst_ni, (cmd_i.resolve && ram_we), (hit_q || free_q))
  // Leaving the scan leaves no read in flight for the resolve step.
  `PHTT_ASSERT_NEXT(a_scan_drained, clk_i, rst_ni, (cmd_i.scan_step && sts_o.scan_done), !cmp_v_q)

endmodule

// ===== src/pointer_handle_translation_table.sv =====
// Channel   Direction  Transaction contents
// s_axis    in         tdata[1:0] func, tdata[65:2] value
// m_axis    out        tdata[63:0] result, tdata[66:64] status
// apb       in/out     register 0 (byte address 0): enable, bit 0
//
// For a table request the single read port of the slot memory is swept once, then a resolve
// step resolves and writes back, and a done step loads the result once the output is free.
// Passthrough, all-ones, disabled and unused-function requests skip the sweep and resolve steps.
// After reset a clearing pass writes every slot; s_axis_tready_o stays low
// during it, while register writes are taken.
// A new request is accepted while the previous result waits; its finish holds until it is taken.
module pointer_handle_translation_table import phtt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // func [1:0], value [65:2], zero fill [71:66]
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // result [63:0], status [66:64], zero fill [71:67]
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [PdataW-1:0]    pwdata,
  output logic [PdataW-1:0]    prdata,
  output logic                 pready
);

  phtt_cmd_t cmd;
  phtt_sts_t sts;
  logic      enable_q, enable_d;
  logic      reg_sel;

  // Register file: one enable bit.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PaddrW-1] == RegIdxEnable);

  always_comb begin
    enable_d = enable_q;
    if (psel && penable && pwrite && pready && reg_sel) begin
      enable_d = pwdata[0];
    end
  end

  assign prdata = reg_sel ? {{(PdataW-1){1'b0}}, enable_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else begin
      enable_q <= enable_d;
    end
  end

  // Controller.
  phtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath with the slot memory.
  phtt_dp #(
    .TableEntries (TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .enable_i    (enable_q),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

// ===== tb/sv/tb_pointer_handle_translation_table.sv =====
module tb_pointer_handle_translation_table;
  timeunit 1ns;
  timeprecision 1ps;
  import phtt_pkg::*;

  localparam int unsigned Slots         = TableEntriesDef;
  localparam time         ClkPeriod     = 8ns;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned SettleCycles  = TableEntriesDef + 12;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PoolMax       = 40;
  localparam int unsigned PrintMax      = 100;

  // The function code that the block leaves unused.
  localparam logic [FuncW-1:0]  FuncUnused = 2'd3;
  localparam logic [PaddrW-1:0] EnableAddr = PaddrW'(4 * int'(RegIdxEnable));
  localparam logic [ValueW-1:0] Split      = 64'h1_0000_0000;
  localparam logic [ValueW-1:0] AllOnes    = '1;

  // One expected response of the table.
  typedef struct {
    logic [ValueW-1:0] result;
    status_e           status;
  } xlate_answer_t;

  // Shadow copy of the translation table and the queue of expected responses.
  class translation_scoreboard;
    bit                enabled;
    bit                slot_used [Slots];
    logic [ValueW-1:0] slot_val  [Slots];
    logic [IndexW-1:0] slot_num  [Slots];
    logic [IndexW-1:0] next_num;
    xlate_answer_t     answers [$];
    int                errors;

    function new();
      enabled  = 1'b1;
      next_num = IndexReset;
      errors   = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function logic [HandleW-1:0] handle_for(logic [IndexW-1:0] num);
      return HandleMark | ({9'b0, num} << 4);
    endfunction

    // Lookups take the lowest matching slot.
    function int find_value(logic [ValueW-1:0] v);
      for (int i = 0; i < Slots; i++) begin
        if (slot_used[i] && slot_val[i] == v) return i;
      end
      return -1;
    endfunction

    function int find_handle(logic [HandleW-1:0] h);
      for (int i = 0; i < Slots; i++) begin
        if (slot_used[i] && handle_for(slot_num[i]) == h) return i;
      end
      return -1;
    endfunction

    function int first_free();
      for (int i = 0; i < Slots; i++) begin
        if (!slot_used[i]) return i;
      end
      return -1;
    endfunction

    // Work out the response of an accepted request and update the shadow table.
    function void note_request(logic [FuncW-1:0] fn, logic [ValueW-1:0] v);
      xlate_answer_t     a;
      int                k;
      logic [HandleW-1:0] h;
      a.result = '0;
      a.status = ST_MISS;
      h = v[HandleW-1:0];
      if (fn == FUNC_H2V) begin
        if ((h & HandleMark) != HandleMark) begin
          a.result = {32'b0, h};
          a.status = ST_PASS;
        end else if (h == '1) begin
          a.result = AllOnes;
          a.status = ST_ONES;
        end else if (!enabled) begin
          a.status = ST_OFF;
        end else begin
          k = find_handle(h);
          if (k >= 0) begin
            a.result = slot_val[k];
            a.status = ST_FOUND;
          end else begin
            a.result = {32'b0, h};
          end
        end
      end else if (fn == FUNC_V2H || fn == FUNC_V2H_DEL) begin
        if (v > Split && (h & HandleMark) != HandleMark) begin
          a.result = {32'b0, h};
          a.status = ST_PASS;
        end else if (v == AllOnes) begin
          a.result = {32'b0, 32'hFFFF_FFFF};
          a.status = ST_ONES;
        end else if (!enabled) begin
          a.status = ST_OFF;
        end else begin
          k = find_value(v);
          if (k >= 0) begin
            a.result = {32'b0, handle_for(slot_num[k])};
            a.status = ST_FOUND;
            if (fn == FUNC_V2H_DEL) slot_used[k] = 1'b0;
          end else if (fn == FUNC_V2H) begin
            k = first_free();
            if (k < 0) begin
              a.status = ST_FULL;
            end else begin
              slot_used[k] = 1'b1;
              slot_val[k]  = v;
              slot_num[k]  = next_num & IndexMask;
              next_num     = (next_num + 1'b1) & IndexMask;
              a.result     = {32'b0, handle_for(slot_num[k])};
              a.status     = ST_ALLOC;
            end
          end
        end
      end
      answers.push_back(a);
    endfunction

    task flag_mismatch(string what, logic [ValueW-1:0] want, logic [ValueW-1:0] got);
      errors++;
      if (errors <= PrintMax) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
    endtask

    // Compare one accepted response with the oldest expectation.
    task check_response(logic [ValueW-1:0] res, logic [StatusW-1:0] st);
      xlate_answer_t a;
      if (answers.size() == 0) begin
        flag_mismatch("unexpected response", '0, res);
        return;
      end
      a = answers.pop_front();
      if (res !== a.result) flag_mismatch("result", a.result, res);
      if (st !== a.status) flag_mismatch("status", 64'(a.status), 64'(st));
    endtask

    function int pending();
      return answers.size();
    endfunction

    // Handle of a randomly chosen live slot, or a random handle if none is live.
    function logic [HandleW-1:0] live_handle();
      int live [$];
      foreach (slot_used[i]) if (slot_used[i]) live.push_back(i);
      if (live.size() == 0) return handle_for(IndexW'($urandom()));
      return handle_for(slot_num[live[$urandom_range(0, live.size() - 1)]]);
    endfunction

    function logic [ValueW-1:0] live_value();
      int live [$];
      foreach (slot_used[i]) if (slot_used[i]) live.push_back(i);
      if (live.size() == 0) return {32'b0, $urandom()};
      return slot_val[live[$urandom_range(0, live.size() - 1)]];
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PaddrW-1:0]    paddr = '0;
  logic [PdataW-1:0]    pwdata = '0;
  logic [PdataW-1:0]    prdata;
  logic                 pready;

  translation_scoreboard sb;
  logic [ValueW-1:0]     value_pool [$];
  bit                    gaps_on = 1'b1;
  bit                    stalls_on = 1'b1;
  bit                    hold_req = 1'b0;
  int unsigned           quiet_cycles = 0;

  pointer_handle_translation_table u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Offer one request, with an occasional idle burst ahead of it.
  task automatic send_request(logic [FuncW-1:0] fn, logic [ValueW-1:0] v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, v, fn};
    do @(posedge clk); while (!s_axis_tready_o);
  endtask

  // Stop offering and wait until every expected response has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_enable(logic en);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EnableAddr;
    pwdata  <= {31'b0, en};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.enabled = en;
  endtask

  // Value that the table stores: either at most 2^32 or carrying the handle pattern.
  function automatic logic [ValueW-1:0] table_value();
    if ($urandom_range(0, 1) == 0) return {32'b0, $urandom()};
    return {$urandom(), $urandom()} | {32'b0, HandleMark};
  endfunction

  // Value above 2^32 with one of the pattern bits cleared.
  function automatic logic [ValueW-1:0] pass_value();
    int b;
    b = $urandom_range(0, 7);
    return {$urandom() | 32'h1, $urandom() & ~(32'h1 << (b < 4 ? b : b + 24))};
  endfunction

  function automatic logic [ValueW-1:0] pool_value();
    logic [ValueW-1:0] v;
    if (value_pool.size() < PoolMax || $urandom_range(0, 3) == 0) begin
      v = table_value();
      if (value_pool.size() < PoolMax) value_pool.push_back(v);
      return v;
    end
    return value_pool[$urandom_range(0, value_pool.size() - 1)];
  endfunction

  // Mostly well-formed traffic on known values and handles, some noise.
  task automatic random_request();
    int                pick;
    logic [HandleW-1:0] h;
    logic [ValueW-1:0]  v;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_request(FUNC_V2H, pool_value());
    end else if (pick < 50) begin
      send_request(FUNC_V2H, sb.live_value());
    end else if (pick < 68) begin
      send_request(FUNC_H2V, {$urandom(), sb.live_handle()});
    end else if (pick < 80) begin
      v = $urandom_range(0, 1) ? sb.live_value() : pool_value();
      send_request(FUNC_V2H_DEL, v);
    end else if (pick < 88) begin
      h = $urandom();
      if ($urandom_range(0, 1) == 0) h = h | HandleMark;
      send_request(FUNC_H2V, {$urandom(), h});
    end else if (pick < 95) begin
      case ($urandom_range(0, 2))
        0:       v = AllOnes;
        1:       v = Split;
        default: v = pass_value();
      endcase
      send_request($urandom_range(0, 1) ? FUNC_V2H : FUNC_V2H_DEL, v);
    end else begin
      send_request(FuncUnused, {$urandom(), $urandom()});
    end
  endtask

  // Accepted transactions on both streams feed the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (s_axis_tvalid && s_axis_tready_o) begin
        sb.note_request(s_axis_tdata[FuncW-1:0], s_axis_tdata[FuncW+ValueW-1:FuncW]);
      end
      if (m_axis_tvalid_o && m_axis_tready) begin
        sb.check_response(m_axis_tdata_o[ValueW-1:0], m_axis_tdata_o[ValueW+StatusW-1:ValueW]);
      end
    end
  end

  // Ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_pointer_handle_translation_table: FAIL");
        $finish;
      end
    end
  end

  // Response side: random stalls, one long hold-off on request.
  initial begin
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) < 3) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat (stalls_on ? $urandom_range(1, 30) : 1) @(posedge clk);
      end
    end
  end

  // Request side: directed cases, then random phases under several settings.
  initial begin
    sb = new();
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // Allocation, lookup, deletion, passthrough, all-ones and unused-function cases with translation on.
    write_enable(1'b1);
    send_request(FUNC_V2H, 64'h0);
    send_request(FUNC_V2H, 64'h0);
    send_request(FUNC_V2H, Split);
    send_request(FUNC_V2H, Split + 64'h1);
    send_request(FUNC_V2H, AllOnes);
    send_request(FUNC_V2H_DEL, AllOnes);
    send_request(FUNC_V2H, 64'hFFFF_FFFF_F000_000F);
    send_request(FUNC_V2H, 64'h0000_0000_FFFF_FFFF);
    send_request(FUNC_H2V, 64'hDEAD_BEEF_F000_001F);
    send_request(FUNC_H2V, 64'h1234_5678_FFFF_FFFF);
    send_request(FUNC_H2V, 64'h0000_0000_1234_5678);
    send_request(FUNC_H2V, 64'hFFFF_FFFF_F7FF_FFFF);
    send_request(FUNC_H2V, 64'h0000_0000_F000_000F);
    send_request(FUNC_V2H_DEL, 64'h0);
    send_request(FUNC_V2H_DEL, 64'h0);
    send_request(FUNC_H2V, 64'h0000_0000_F000_001F);
    send_request(FUNC_V2H, 64'h0);
    send_request(FuncUnused, AllOnes);
    send_request(FuncUnused, 64'h0);
    send_request(FUNC_V2H, 64'h8000_0000_0000_0000);
    drain();

    // Translation off: table requests answer disabled, the table keeps its contents.
    write_enable(1'b0);
    send_request(FUNC_V2H, 64'h0);
    send_request(FUNC_H2V, 64'h0000_0000_F000_001F);
    send_request(FUNC_V2H_DEL, Split);
    send_request(FUNC_V2H, 64'h8000_0000_0000_0000);
    send_request(FUNC_H2V, 64'h0000_0000_FFFF_FFFF);
    drain();
    write_enable(1'b1);

    // Random traffic, starting with a long hold-off on the response side.
    hold_req = 1'b1;
    repeat (150) random_request();

    // Send more allocations than the table has slots, so it reports full, then free some slots.
    repeat (70) send_request(FUNC_V2H, {$urandom(), $urandom()} | {32'b0, HandleMark});
    repeat (20) send_request(FUNC_V2H_DEL, sb.live_value());
    drain();

    write_enable(1'b0);
    repeat (35) random_request();
    drain();
    write_enable(1'b1);

    // Last stretch at full rate on both sides.
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (120) random_request();
    drain();

    if (sb.errors == 0) begin
      $display("tb_pointer_handle_translation_table: PASS");
    end else begin
      $display("tb_pointer_handle_translation_table: FAIL");
    end
    $finish;
  end

endmodule
